/* rtl/shg_pkg.sv */
// Shared constants and command codes for the scatter histogram grid.
// No dependencies; imported by scatter_histogram_2d and shg_checker (shg_ram does not use it).
package shg_pkg;

  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 8;
  localparam int WHOLE_W   = COORD_W - FRAC_BITS;
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 32;

  localparam logic signed [COORD_W-1:0] NULL_LIMIT_RST = 24'sh7FFFFF;

  localparam logic [1:0] CMD_ACCUM    = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_READ_CLR = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

/* rtl/scatter_histogram_2d.sv */
// Scatter histogram grid: one item per cycle while in_ready is high; a read result is registered in
// stage 1 and then in the output register, and out_ready low holds it back there.
// Rate is set by the bin RAM's read-modify-write loop, closed by a one-entry forward register.
// Reset (rst_n low, synchronous) starts a clearing pass over all GRID_ROWS*GRID_COLS bins,
// one bin a cycle, during which in_ready stays low; configuration writes are taken throughout.
module scatter_histogram_2d #(
  parameter int GRID_ROWS  = 256,
  parameter int GRID_COLS  = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  shg_pkg::coord_t                   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  shg_pkg::coord_t                   in_x_coord,
  input  shg_pkg::coord_t                   in_y_coord,
  input  logic [shg_pkg::IDX_W-1:0]         in_read_row,
  input  logic [shg_pkg::IDX_W-1:0]         in_read_col,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [shg_pkg::CNT_OUT_W-1:0]     out_bin_count,
  output logic [shg_pkg::IDX_W-1:0]         out_bin_row,
  output logic [shg_pkg::IDX_W-1:0]         out_bin_col
);
  import shg_pkg::*;

  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam logic signed [WHOLE_W-1:0] ROW_LAST = WHOLE_W'(GRID_ROWS - 1);
  localparam logic signed [WHOLE_W-1:0] COL_LAST = WHOLE_W'(GRID_COLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(GRID_COLS);

  coord_t null_limit_r;

  // clearing pass
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // stage 1: RAM data is present
  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic              s1_keep_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;

  // last write to the bin store
  logic                  fwd_valid_r;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic                  out_valid_r;
  logic [CNT_OUT_W-1:0]  out_count_r;
  logic [IDX_W-1:0]      out_row_r;
  logic [IDX_W-1:0]      out_col_r;

  logic                  accept;
  logic                  s1_is_read;
  logic                  s1_stall;
  logic                  s1_fire;
  logic                  s1_wr;
  logic signed [WHOLE_W-1:0] x_whole;
  logic signed [WHOLE_W-1:0] y_whole;
  logic [COL_W-1:0]      acc_col;
  logic [ROW_W-1:0]      acc_row;
  logic [WHOLE_W-1:0]    rd_row_wide;
  logic [WHOLE_W-1:0]    rd_col_wide;
  logic [ROW_W-1:0]      rd_row;
  logic [COL_W-1:0]      rd_col;
  logic [ROW_W-1:0]      sel_row;
  logic [COL_W-1:0]      sel_col;
  logic [ADDR_W-1:0]     sel_addr;
  logic                  sample_ok;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS+CNT_OUT_W-1:0] count_wide;
  logic [ROW_W+IDX_W-1:0] row_wide;
  logic [COL_W+IDX_W-1:0] col_wide;

  // Stage 0: bin address from the incoming transaction
  always_comb begin
    x_whole = in_x_coord[COORD_W-1:FRAC_BITS];
    y_whole = in_y_coord[COORD_W-1:FRAC_BITS];
    if (x_whole < 0) begin
      acc_col = '0;
    end else if (x_whole > COL_LAST) begin
      acc_col = COL_LAST[COL_W-1:0];
    end else begin
      acc_col = x_whole[COL_W-1:0];
    end
    if (y_whole < 0) begin
      acc_row = '0;
    end else if (y_whole > ROW_LAST) begin
      acc_row = ROW_LAST[ROW_W-1:0];
    end else begin
      acc_row = y_whole[ROW_W-1:0];
    end
    rd_row_wide = {{(WHOLE_W-IDX_W){1'b0}}, in_read_row};
    rd_col_wide = {{(WHOLE_W-IDX_W){1'b0}}, in_read_col};
    rd_row = (rd_row_wide > ROW_LAST) ? ROW_LAST[ROW_W-1:0] : rd_row_wide[ROW_W-1:0];
    rd_col = (rd_col_wide > COL_LAST) ? COL_LAST[COL_W-1:0] : rd_col_wide[COL_W-1:0];
    if (in_cmd == CMD_ACCUM) begin
      sel_row = acc_row;
      sel_col = acc_col;
    end else begin
      sel_row = rd_row;
      sel_col = rd_col;
    end
    sel_addr  = ADDR_W'(sel_row) * COLS_A + ADDR_W'(sel_col);
    sample_ok = (in_x_coord < null_limit_r) && (in_y_coord < null_limit_r);
  end

  assign s1_is_read = (s1_cmd_r == CMD_READ) || (s1_cmd_r == CMD_READ_CLR);
  assign s1_stall   = s1_valid_r && s1_is_read && out_valid_r && !out_ready;
  assign s1_fire    = s1_valid_r && !s1_stall;
  assign in_ready   = !clr_busy_r && !s1_stall;
  assign accept     = in_valid && in_ready;

  // Stage 1: modify with forwarding of the previous write
  always_comb begin
    cur_count = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
    new_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
    s1_wr     = s1_fire && (((s1_cmd_r == CMD_ACCUM) && s1_keep_r) ||
                            (s1_cmd_r == CMD_READ_CLR));
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_addr_r;
      ram_wdata = (s1_cmd_r == CMD_ACCUM) ? new_count : '0;
    end
    count_wide = {{CNT_OUT_W{1'b0}}, cur_count};
    row_wide   = {{IDX_W{1'b0}}, s1_row_r};
    col_wide   = {{IDX_W{1'b0}}, s1_col_r};
  end

  shg_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (sel_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_limit_r <= NULL_LIMIT_RST;
      clr_busy_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        null_limit_r <= cfg_wr_data;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_wr) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_fire && s1_is_read) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r  <= in_cmd;
      s1_keep_r <= sample_ok;
      s1_addr_r <= sel_addr;
      s1_row_r  <= sel_row;
      s1_col_r  <= sel_col;
    end
    if (s1_wr) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= ram_wdata;
    end
    if (s1_fire && s1_is_read) begin
      out_count_r <= count_wide[CNT_OUT_W-1:0];
      out_row_r   <= row_wide[IDX_W-1:0];
      out_col_r   <= col_wide[IDX_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_count_r;
  assign out_bin_row   = out_row_r;
  assign out_bin_col   = out_col_r;

endmodule

/* rtl/shg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read of the address being written returns the old contents.
module shg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/shg_checker.sv */
// Port-level checks for scatter_histogram_2d, bound to the top level below.
// Depends on shg_pkg for field widths and command codes.
module shg_checker #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [shg_pkg::CNT_OUT_W-1:0] out_bin_count,
  input logic [shg_pkg::IDX_W-1:0]     out_bin_row,
  input logic [shg_pkg::IDX_W-1:0]     out_bin_col
);
  import shg_pkg::*;

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_count) &&
      $stable(out_bin_row) && $stable(out_bin_col))
    else $error("result changed while stalled");

  // clearing pass blocks input straight after reset
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted during clearing pass");

  // a read transaction always finds a result on show after stage 1 and the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_READ || in_cmd == CMD_READ_CLR)
      |=> ##1 out_valid)
    else $error("read result missing");

  // reported bin lies on the grid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (GRID_ROWS > 256 || out_bin_row <= IDX_W'(GRID_ROWS - 1)) &&
      (GRID_COLS > 256 || out_bin_col <= IDX_W'(GRID_COLS - 1)))
    else $error("reported bin off the grid");

endmodule

bind scatter_histogram_2d shg_checker #(
  .GRID_ROWS (GRID_ROWS),
  .GRID_COLS (GRID_COLS)
) u_shg_checker (.*);
